[sv/dxt_pkg.sv]
`default_nettype none

package dxt_pkg;

    // format register codes, bit 1 alone selects interpolated alpha
    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;

    localparam int TEXELS = 16;

    // reciprocal constants for truncating division by 3, 5 and 7
    localparam logic [10:0] DIV3_MUL   = 11'd683;
    localparam int          DIV3_SHIFT = 11;
    localparam logic [10:0] DIV5_MUL   = 11'd1639;
    localparam int          DIV5_SHIFT = 13;
    localparam logic [11:0] DIV7_MUL   = 12'd2341;
    localparam int          DIV7_SHIFT = 14;

    typedef struct packed {
        logic [63:0] color_block;
        logic [63:0] alpha_block;
    } dxt_in_t;

    typedef struct packed {
        logic [3:0] texel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } dxt_out_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // everything the texel stage needs for one block
    typedef struct packed {
        rgb_t [3:0]      col;
        logic            col3_clear;
        logic [7:0][7:0] apal;
        logic [31:0]     cidx;
        logic [63:0]     ablk;
        logic            dxt5;
        logic            dxt3;
    } blk_t;

    function automatic logic [31:0][7:0] exp5_lut();
        logic [31:0][7:0] t;
        for (int i = 0; i < 32; i++) begin
            t[i] = 8'((i * 255) / 31);
        end
        return t;
    endfunction

    function automatic logic [63:0][7:0] exp6_lut();
        logic [63:0][7:0] t;
        for (int i = 0; i < 64; i++) begin
            t[i] = 8'((i * 255) / 63);
        end
        return t;
    endfunction

    localparam logic [31:0][7:0] EXP5_LUT = exp5_lut();
    localparam logic [63:0][7:0] EXP6_LUT = exp6_lut();

    // n <= 765
    function automatic logic [7:0] div3(input logic [9:0] n);
        logic [20:0] p;
        p = 21'(n) * 21'(DIV3_MUL);
        return p[DIV3_SHIFT +: 8];
    endfunction

    // n <= 1275
    function automatic logic [7:0] div5(input logic [10:0] n);
        logic [21:0] p;
        p = 22'(n) * 22'(DIV5_MUL);
        return p[DIV5_SHIFT +: 8];
    endfunction

    // n <= 1785
    function automatic logic [7:0] div7(input logic [10:0] n);
        logic [22:0] p;
        p = 23'(n) * 23'(DIV7_MUL);
        return p[DIV7_SHIFT +: 8];
    endfunction

endpackage

`default_nettype wire

[sv/dxt_color_pal.sv]
`default_nettype none

module dxt_color_pal
    import dxt_pkg::*;
(
    input  wire logic [31:0] endpoints,
    input  wire logic        punch,
    output rgb_t [3:0]       col,
    output logic             col3_clear
);

    logic [15:0]      c0;
    logic [15:0]      c1;
    logic [2:0][7:0]  e0;
    logic [2:0][7:0]  e1;
    logic [2:0][7:0]  p2;
    logic [2:0][7:0]  p3;
    logic [8:0]       sum_mid;
    logic [9:0]       sum_a;
    logic [9:0]       sum_b;

    assign c0 = endpoints[15:0];
    assign c1 = endpoints[31:16];

    // channel 2 red, 1 green, 0 blue
    assign e0[2] = EXP5_LUT[c0[15:11]];
    assign e0[1] = EXP6_LUT[c0[10:5]];
    assign e0[0] = EXP5_LUT[c0[4:0]];
    assign e1[2] = EXP5_LUT[c1[15:11]];
    assign e1[1] = EXP6_LUT[c1[10:5]];
    assign e1[0] = EXP5_LUT[c1[4:0]];

    assign col3_clear = punch && (c0 <= c1);

    always_comb begin
        sum_mid = '0;
        sum_a   = '0;
        sum_b   = '0;
        for (int ch = 0; ch < 3; ch++) begin
            sum_mid = 9'(e0[ch]) + 9'(e1[ch]);
            sum_a   = {1'b0, e0[ch], 1'b0} + 10'(e1[ch]);
            sum_b   = 10'(e0[ch]) + {1'b0, e1[ch], 1'b0};
            if (col3_clear) begin
                p2[ch] = sum_mid[8:1];
                p3[ch] = '0;
            end else begin
                p2[ch] = div3(sum_a);
                p3[ch] = div3(sum_b);
            end
        end
    end

    assign col[0] = '{red: e0[2], green: e0[1], blue: e0[0]};
    assign col[1] = '{red: e1[2], green: e1[1], blue: e1[0]};
    assign col[2] = '{red: p2[2], green: p2[1], blue: p2[0]};
    assign col[3] = '{red: p3[2], green: p3[1], blue: p3[0]};

endmodule

`default_nettype wire

[sv/dxt_alpha_pal.sv]
`default_nettype none

module dxt_alpha_pal
    import dxt_pkg::*;
(
    input  wire logic [15:0] endpoints,
    output logic [7:0][7:0]  apal
);

    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [10:0] s7;
    logic [10:0] s5;

    assign a0 = endpoints[7:0];
    assign a1 = endpoints[15:8];

    always_comb begin
        s7 = '0;
        s5 = '0;
        apal[0] = a0;
        apal[1] = a1;
        for (int k = 2; k < 8; k++) begin
            s7 = 11'(3'(8 - k) * a0) + 11'(3'(k - 1) * a1);
            if (a0 > a1) begin
                apal[k] = div7(s7);
            end else if (k < 6) begin
                s5 = 11'(3'(6 - k) * a0) + 11'(3'(k - 1) * a1);
                apal[k] = div5(s5);
            end else if (k == 6) begin
                apal[k] = 8'd0;
            end else begin
                apal[k] = 8'd255;
            end
        end
    end

endmodule

`default_nettype wire

[sv/dxt_texel_sel.sv]
`default_nettype none

module dxt_texel_sel
    import dxt_pkg::*;
(
    input  wire blk_t        blk,
    input  wire logic [3:0]  cnt,
    output dxt_out_t         texel
);

    logic [1:0] ci;
    logic [3:0] nib;
    logic [5:0] abit;
    logic [2:0] aidx;
    rgb_t       c;
    logic [7:0] a;

    assign ci   = blk.cidx[{cnt, 1'b0} +: 2];
    assign nib  = blk.ablk[{cnt, 2'b00} +: 4];
    assign abit = 6'd16 + 6'(cnt) * 6'd3;
    assign aidx = blk.ablk[abit +: 3];
    assign c    = blk.col[ci];

    always_comb begin
        if (blk.dxt5) begin
            a = blk.apal[aidx];
        end else if (blk.dxt3) begin
            a = {nib, nib};
        end else if (ci == 2'd3 && blk.col3_clear) begin
            a = 8'd0;
        end else begin
            a = 8'd255;
        end
    end

    assign texel = '{
        texel_index: cnt,
        red:         c.red,
        green:       c.green,
        blue:        c.blue,
        alpha:       a,
        last:        (cnt == 4'(TEXELS - 1))
    };

endmodule

`default_nettype wire

[sv/dxt_texture_block_decoder.sv]
// dxt texture block decoder: one compressed 4x4 block in, sixteen texels out
//
// input channel (s_): one word per block, colour half and alpha half of a
//   DXT1/DXT3/DXT5 block; the alpha half is ignored for DXT1
// result channel (m_): one word per texel in raster order, with its index
//   and a last flag on texel 15
// cfg_we/cfg_wdata: block format, 0 DXT1 with punch-through, 1 DXT3,
//   2 or 3 DXT5; write it only while no block is in flight
//
// latency: the first texel shows on m_ two cycles after the block is taken,
//   the last one seventeen cycles after, with no stall on the result side
// throughput: sixteen cycles per block, one texel per cycle, set by the
//   single texel output register; the next block is held in the input
//   register and its palette is built in the cycle the last texel leaves
// stalls: with m_ready low the current texel holds on m_data and the texel
//   counter waits; the input register still takes one more block
// reset: clears all valid flags and the texel counter and returns the
//   format to DXT1; payload registers keep whatever they hold

`default_nettype none

module dxt_texture_block_decoder
    import dxt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dxt_in_t    s_data,

    output logic            m_valid,
    input  wire logic       m_ready,
    output dxt_out_t        m_data,

    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata
);

    // format register
    logic [1:0] fmt_reg;

    // input register, one block word
    logic       in_valid_reg;
    dxt_in_t    in_reg;

    // palette register and texel counter
    logic       pal_valid_reg;
    blk_t       pal_reg;
    blk_t       pal_next;
    logic [3:0] cnt_reg;

    // result register
    logic       m_valid_reg;
    dxt_out_t   m_data_reg;
    dxt_out_t   texel;

    logic       move;
    logic       load_pal;
    logic       in_take;

    // a texel moves into the result register when it is empty or being drained
    assign move     = pal_valid_reg && (!m_valid_reg || m_ready);
    // the palette register frees up as its last texel moves out
    assign load_pal = in_valid_reg
                      && (!pal_valid_reg || (move && cnt_reg == 4'(TEXELS - 1)));
    assign s_ready  = !in_valid_reg || load_pal;
    assign in_take  = s_valid && s_ready;

    // palette build from the input register
    dxt_color_pal u_color_pal (
        .endpoints  (in_reg.color_block[31:0]),
        .punch      (fmt_reg == FMT_DXT1),
        .col        (pal_next.col),
        .col3_clear (pal_next.col3_clear)
    );

    dxt_alpha_pal u_alpha_pal (
        .endpoints (in_reg.alpha_block[15:0]),
        .apal      (pal_next.apal)
    );

    assign pal_next.cidx = in_reg.color_block[63:32];
    assign pal_next.ablk = in_reg.alpha_block;
    assign pal_next.dxt5 = fmt_reg[1];
    assign pal_next.dxt3 = (fmt_reg == FMT_DXT3);

    // per texel selection
    dxt_texel_sel u_texel_sel (
        .blk   (pal_reg),
        .cnt   (cnt_reg),
        .texel (texel)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg       <= FMT_DXT1;
            in_valid_reg  <= 1'b0;
            pal_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                fmt_reg <= cfg_wdata;
            end

            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (load_pal) begin
                in_valid_reg <= 1'b0;
            end

            if (load_pal) begin
                pal_valid_reg <= 1'b1;
            end else if (move && cnt_reg == 4'(TEXELS - 1)) begin
                pal_valid_reg <= 1'b0;
            end

            // wraps to zero after the last texel
            if (move) begin
                cnt_reg <= cnt_reg + 4'd1;
            end

            if (move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_reg <= s_data;
        end
        if (load_pal) begin
            pal_reg <= pal_next;
        end
        if (move) begin
            m_data_reg <= texel;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // texels of one block leave in order
    a_texel_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last)
        |=> (!m_valid || m_data.texel_index == $past(m_data.texel_index) + 4'd1))
        else $error("texel index out of order");

    // a new block starts at texel zero
    a_block_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last)
        |=> (!m_valid || m_data.texel_index == 4'd0))
        else $error("block did not start at texel zero");

    // counter rests at zero between blocks
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !pal_valid_reg |-> cnt_reg == 4'd0)
        else $error("texel counter not at zero while idle");

    // the palette register is only overwritten once its last texel has gone
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_pal && pal_valid_reg) |-> (move && cnt_reg == 4'(TEXELS - 1)))
        else $error("palette overwritten mid block");

endmodule

`default_nettype wire
